// File: hdl/b2da_pkg.sv
// Shared constants and types for the binary to decimal ASCII converter.
`timescale 1ns / 1ps

package b2da_pkg;

  localparam int FIELD_DIGITS = 20;
  localparam int VALUE_BITS   = 64;

  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 6;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 8;

  localparam int BIT_CNT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int CHAR_CNT_W = (FIELD_DIGITS > 1) ? $clog2(FIELD_DIGITS) : 1;

  localparam logic [CHAR_W-1:0] ASCII_SPACE = CHAR_W'(32);
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);

  localparam logic [BIT_CNT_W-1:0]  LAST_BIT  = BIT_CNT_W'(VALUE_BITS - 1);
  localparam logic [CHAR_CNT_W-1:0] LAST_CHAR = CHAR_CNT_W'(FIELD_DIGITS - 1);

  // Operation applied to all digit cells together.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_CLEAR,
    OP_DABBLE,
    OP_DIGIT
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_EMIT
  } state_t;

endpackage

// File: hdl/b2da_cell.sv
// One BCD digit cell of the double-dabble chain.
`timescale 1ns / 1ps

module b2da_cell (
  input  logic                          clk,
  input  b2da_pkg::cell_op_t            op,
  input  logic                          bit_in,
  input  logic [b2da_pkg::DIGIT_W-1:0]  digit_in,
  output logic [b2da_pkg::DIGIT_W-1:0]  digit,
  output logic                          carry_out
);
  import b2da_pkg::*;

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;
  logic [DIGIT_W-1:0] adj;

  // Add three before the shift when the digit would overflow past nine.
  assign adj       = (digit_r >= DIGIT_W'(5)) ? (digit_r + DIGIT_W'(3)) : digit_r;
  assign carry_out = adj[DIGIT_W-1];
  assign digit     = digit_r;

  always_comb begin
    case (op)
      OP_CLEAR:  digit_nxt = '0;
      OP_DABBLE: digit_nxt = {adj[DIGIT_W-2:0], bit_in};
      OP_DIGIT:  digit_nxt = digit_in;
      default:   digit_nxt = digit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

// File: hdl/binary_to_decimal_ascii.sv
// Binary to decimal ASCII converter: control and a chain of digit cells.
//
// Input stream (in_*): one transaction carries a 64-bit unsigned value in
// in_tdata. Output stream (out_*): per value, a field of 20 ASCII characters,
// most significant position first, right-justified with leading spaces; zero
// prints a single '0' in the last position. out_tlast marks the 20th char.
// Sequence: the value is taken while idle, then the digit chain runs one
// shift-and-adjust step per value bit, then the chain shifts one digit
// per cycle toward the top cell, which drives the output, while out_tready
// is high. A new value is taken only after the whole field has gone out;
// in_tready is high only while the block is idle.
// A stall on out_tready holds the current character and the chain; nothing
// is dropped. Reset returns the control to idle and drops any field that is
// in progress; the digit cells need no reset.
`timescale 1ns / 1ps

module binary_to_decimal_ascii (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [b2da_pkg::IN_DATA_W-1:0]     in_tdata,   // [63:0] value
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [b2da_pkg::OUT_DATA_W-1:0]    out_tdata,  // [5:0] ascii_char
  output logic                               out_tlast   // last_char
);
  import b2da_pkg::*;

  state_t                 state_r, state_nxt;
  logic [VALUE_BITS-1:0]  shift_r, shift_nxt;
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [CHAR_CNT_W-1:0]  char_cnt_r, char_cnt_nxt;
  logic                   seen_r, seen_nxt;
  cell_op_t               op;

  logic [DIGIT_W-1:0] cell_digit [FIELD_DIGITS];
  logic               cell_carry [FIELD_DIGITS];

  logic [DIGIT_W-1:0] top_digit;
  logic               is_last;
  logic               blank;
  logic [CHAR_W-1:0]  ascii_char;

  genvar gi;
  generate
    for (gi = 0; gi < FIELD_DIGITS; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        b2da_cell u_cell (
          .clk       (clk),
          .op        (op),
          .bit_in    (shift_r[VALUE_BITS-1]),
          .digit_in  ('0),
          .digit     (cell_digit[gi]),
          .carry_out (cell_carry[gi])
        );
      end else begin : g_rest
        b2da_cell u_cell (
          .clk       (clk),
          .op        (op),
          .bit_in    (cell_carry[gi-1]),
          .digit_in  (cell_digit[gi-1]),
          .digit     (cell_digit[gi]),
          .carry_out (cell_carry[gi])
        );
      end
    end
  endgenerate

  // The top cell's carry is unused: a 64-bit value fits in the 20-digit field.
  assign top_digit  = cell_digit[FIELD_DIGITS-1];
  assign is_last    = (char_cnt_r == LAST_CHAR);
  assign blank      = !seen_r && (top_digit == '0) && !is_last;
  assign ascii_char = blank ? ASCII_SPACE : (ASCII_ZERO + CHAR_W'(top_digit));

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_EMIT);
  assign out_tdata  = {{(OUT_DATA_W - CHAR_W){1'b0}}, ascii_char};
  assign out_tlast  = is_last;

  always_comb begin
    state_nxt    = state_r;
    shift_nxt    = shift_r;
    bit_cnt_nxt  = bit_cnt_r;
    char_cnt_nxt = char_cnt_r;
    seen_nxt     = seen_r;
    op           = OP_HOLD;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          shift_nxt   = in_tdata[VALUE_BITS-1:0];
          bit_cnt_nxt = '0;
          op          = OP_CLEAR;
          state_nxt   = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        op          = OP_DABBLE;
        shift_nxt   = {shift_r[VALUE_BITS-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + BIT_CNT_W'(1);
        if (bit_cnt_r == LAST_BIT) begin
          char_cnt_nxt = '0;
          seen_nxt     = 1'b0;
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_tready) begin
          // Advance the next digit into the top cell.
          op           = OP_DIGIT;
          char_cnt_nxt = char_cnt_r + CHAR_CNT_W'(1);
          seen_nxt     = seen_r || (top_digit != '0);
          if (is_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r    <= shift_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    char_cnt_r <= char_cnt_nxt;
    seen_r     <= seen_nxt;
  end

endmodule
